// ===== rtl/pearson_correlation_of_returns_macros.svh =====
// Assertion macros shared by the checker.
`ifndef PEARSON_CORRELATION_OF_RETURNS_MACROS_SVH
`define PEARSON_CORRELATION_OF_RETURNS_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcr assertion failed");

// Next-cycle implication, switched off while reset is held.
`define PCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcr assertion failed");

// Checked in the cycle after reset is held.
`define PCR_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("pcr reset assertion failed");

`endif

// ===== rtl/pcr_pkg.sv =====
package pcr_pkg;
  localparam int MAX_RETURNS = 1024;
  localparam int ADDR_W = $clog2(MAX_RETURNS);
  localparam int CNT_W = $clog2(MAX_RETURNS + 2);
  localparam int PRICE_W = 32;
  localparam int RET_W = 32;
  localparam int SUM_W = RET_W + ADDR_W;
  localparam int CORR_W = 32;
  localparam int STATUS_W = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_ZERO = 2'd1;
  localparam kind_t KIND_OVF  = 2'd2;
  localparam kind_t KIND_RET  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_PRICE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_VAR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic [PRICE_W-1:0] price_a;
    logic [PRICE_W-1:0] price_b;
    logic [PRICE_W-1:0] prev_a;
    logic [PRICE_W-1:0] prev_b;
    kind_t              kind;
    logic               last;
  } pcr_ent_t;
endpackage

// ===== rtl/pcr_in_if.sv =====
interface pcr_in_if;
  import pcr_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price_a;
  logic [PRICE_W-1:0] price_b;
  logic               last;
  modport source (output valid, price_a, price_b, last, input ready);
  modport sink (input valid, price_a, price_b, last, output ready);
endinterface

// ===== rtl/pcr_out_if.sv =====
interface pcr_out_if;
  import pcr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] correlation;
  logic [STATUS_W-1:0]      status;
  modport source (output valid, correlation, status, input ready);
  modport sink (input valid, correlation, status, output ready);
endinterface

// ===== rtl/pcr_front.sv =====
module pcr_front (
  input  logic              clk,
  input  logic              rst_n,
  pcr_in_if.sink            in_chan,
  output logic              push_valid,
  output pcr_pkg::pcr_ent_t push_data,
  input  logic              push_ready
);
  import pcr_pkg::*;

  logic [CNT_W-1:0]   pc_r;
  logic [PRICE_W-1:0] prev_a_r;
  logic [PRICE_W-1:0] prev_b_r;
  kind_t              kind;
  logic               accept;

  assign in_chan.ready = push_ready;
  assign push_valid = in_chan.valid;
  assign accept = in_chan.valid && push_ready;

  always_comb begin
    if (pc_r == '0) begin
      kind = KIND_NONE;
    end else if (prev_a_r == '0 || prev_b_r == '0) begin
      kind = KIND_ZERO;
    end else if (pc_r > CNT_W'(MAX_RETURNS)) begin
      kind = KIND_OVF;
    end else begin
      kind = KIND_RET;
    end
  end

  always_comb begin
    push_data.price_a = in_chan.price_a;
    push_data.price_b = in_chan.price_b;
    push_data.prev_a  = prev_a_r;
    push_data.prev_b  = prev_b_r;
    push_data.kind    = kind;
    push_data.last    = in_chan.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      prev_a_r <= '0;
      prev_b_r <= '0;
    end else if (accept) begin
      if (in_chan.last) begin
        pc_r     <= '0;
        prev_a_r <= '0;
        prev_b_r <= '0;
      end else begin
        if (pc_r <= CNT_W'(MAX_RETURNS)) begin
          pc_r <= pc_r + 1'b1;
        end
        prev_a_r <= in_chan.price_a;
        prev_b_r <= in_chan.price_b;
      end
    end
  end
endmodule

// ===== rtl/pcr_fifo.sv =====
module pcr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  pcr_pkg::pcr_ent_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output pcr_pkg::pcr_ent_t pop_data,
  input  logic              pop
);
  import pcr_pkg::*;

  pcr_ent_t   slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end
endmodule

// ===== rtl/pcr_div.sv =====
module pcr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] num_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [63:0] quo_r;
  logic [32:0] trial;
  logic        qbit;

  assign done = done_r;
  assign quo  = quo_r;
  assign trial = {rem_r, num_r[63]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[62:0], 1'b0};
      rem_r <= qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quo_r <= {quo_r[62:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/pcr_back.sv =====
module pcr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  input  pcr_pkg::pcr_ent_t pop_data,
  output logic              pop,
  output logic              div_start,
  output logic [63:0]       div_num,
  output logic [31:0]       div_den,
  input  logic              div_done,
  input  logic [63:0]       div_quo,
  pcr_out_if.source         out_chan
);
  import pcr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_DIVA   = 4'd2;
  localparam logic [3:0] S_DIVB   = 4'd3;
  localparam logic [3:0] S_FINAL  = 4'd4;
  localparam logic [3:0] S_MEANA  = 4'd5;
  localparam logic [3:0] S_MEANB  = 4'd6;
  localparam logic [3:0] S_PASS   = 4'd7;
  localparam logic [3:0] S_CHECK  = 4'd8;
  localparam logic [3:0] S_NORM   = 4'd9;
  localparam logic [3:0] S_SQRT   = 4'd10;
  localparam logic [3:0] S_PROD   = 4'd11;
  localparam logic [3:0] S_RSTART = 4'd12;
  localparam logic [3:0] S_RATIO  = 4'd13;
  localparam logic [3:0] S_SCALE  = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  localparam logic [63:0] NORM4_MIN = 64'h1 << 60;
  localparam logic [63:0] NORM2_MIN = 64'h1 << 61;
  localparam logic [63:0] ONE_Q30   = 64'h1 << 30;
  localparam logic [63:0] RET_MAX   = 64'h7FFF_FFFF;

  logic [3:0]                 state_r;
  pcr_ent_t                   ent_r;
  logic [1:0]                 flags_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           idx_r;
  logic signed [SUM_W-1:0]    sum_a_r;
  logic signed [SUM_W-1:0]    sum_b_r;
  logic [RET_W-1:0]           ra_r;
  logic [RET_W-1:0]           mem_a [MAX_RETURNS];
  logic [RET_W-1:0]           mem_b [MAX_RETURNS];
  logic [RET_W-1:0]           rd_a_r;
  logic [RET_W-1:0]           rd_b_r;
  logic                       mem_we;
  logic [RET_W-1:0]           rb_new;
  logic [2:0]                 ph_r;
  logic signed [RET_W-1:0]    ma_r;
  logic signed [RET_W-1:0]    mb_r;
  logic [31:0]                ua_r;
  logic [31:0]                ub_r;
  logic                       na_neg_r;
  logic                       nb_neg_r;
  logic [63:0]                prod_r;
  logic [31:0]                mul_x;
  logic [31:0]                mul_y;
  logic [63:0]                mul_res;
  logic [63:0]                c1_r;
  logic [63:0]                c2_r;
  logic signed [63:0]         c_r;
  logic [63:0]                na_r;
  logic [63:0]                nb_r;
  logic [63:0]                nc_r;
  logic [5:0]                 ka_r;
  logic [5:0]                 kb_r;
  logic [5:0]                 kc_r;
  logic [63:0]                ya_r;
  logic [63:0]                yb_r;
  logic [63:0]                qa_r;
  logic [63:0]                qb_r;
  logic [63:0]                bit_r;
  logic [63:0]                ta;
  logic [63:0]                tb;
  logic [63:0]                p_r;
  logic                       div_go_r;
  logic [63:0]                div_num_r;
  logic [31:0]                div_den_r;
  logic [STATUS_W-1:0]        status_r;
  logic signed [CORR_W-1:0]   corr_r;
  logic [PRICE_W-1:0]         dif_a;
  logic [PRICE_W-1:0]         dif_b;
  logic [SUM_W-1:0]           sum_a_mag;
  logic [SUM_W-1:0]           sum_b_mag;
  logic signed [33:0]         da;
  logic signed [33:0]         db;
  logic [33:0]                da_mag;
  logic [33:0]                db_mag;
  logic signed [7:0]          e;
  logic [7:0]                 neg_e;
  logic [63:0]                r_ext;
  logic [63:0]                v;
  logic [63:0]                v_cl;

  function automatic logic [RET_W-1:0] sat_ret(input logic [63:0] q, input logic neg);
    logic [RET_W-1:0] res;
    if (neg) begin
      res = RET_W'(-q[RET_W-1:0]);
    end else if (q > RET_MAX) begin
      res = RET_MAX[RET_W-1:0];
    end else begin
      res = q[RET_W-1:0];
    end
    return res;
  endfunction

  assign pop       = (state_r == S_IDLE) && pop_valid;
  assign div_start = div_go_r;
  assign div_num   = div_num_r;
  assign div_den   = div_den_r;

  assign out_chan.valid       = (state_r == S_OUT);
  assign out_chan.correlation = corr_r;
  assign out_chan.status      = status_r;

  assign dif_a = (ent_r.price_a >= ent_r.prev_a) ? ent_r.price_a - ent_r.prev_a
                                                 : ent_r.prev_a - ent_r.price_a;
  assign dif_b = (ent_r.price_b >= ent_r.prev_b) ? ent_r.price_b - ent_r.prev_b
                                                 : ent_r.prev_b - ent_r.price_b;
  assign sum_a_mag = sum_a_r[SUM_W-1] ? SUM_W'(-sum_a_r) : SUM_W'(sum_a_r);
  assign sum_b_mag = sum_b_r[SUM_W-1] ? SUM_W'(-sum_b_r) : SUM_W'(sum_b_r);

  assign rb_new = sat_ret(div_quo, ent_r.price_b < ent_r.prev_b);
  assign mem_we = (state_r == S_DIVB) && div_done;

  assign da = 34'($signed(rd_a_r)) - 34'(ma_r);
  assign db = 34'($signed(rd_b_r)) - 34'(mb_r);
  assign da_mag = da[33] ? 34'(-da) : 34'(da);
  assign db_mag = db[33] ? 34'(-db) : 34'(db);

  // One shared multiplier: squares and cross products in the pass, then the root product.
  always_comb begin
    mul_x = ua_r;
    mul_y = ua_r;
    if (state_r == S_PROD) begin
      mul_x = qa_r[31:0];
      mul_y = qb_r[31:0];
    end else if (ph_r == 3'd3) begin
      mul_x = ub_r;
      mul_y = ub_r;
    end else if (ph_r == 3'd4) begin
      mul_y = ub_r;
    end
  end
  assign mul_res = 64'(mul_x) * 64'(mul_y);

  assign ta = qa_r + bit_r;
  assign tb = qb_r + bit_r;

  assign e     = 8'(ka_r) + 8'(kb_r) - 8'(kc_r);
  assign neg_e = 8'(-e);
  assign r_ext = {32'b0, div_quo[31:0]};
  always_comb begin
    if (e >= 8'sd32) begin
      v = ONE_Q30;
    end else if (e >= 8'sd0) begin
      v = r_ext << e[4:0];
    end else if (neg_e >= 8'd64) begin
      v = '0;
    end else begin
      v = r_ext >> neg_e[5:0];
    end
    v_cl = (v > ONE_Q30) ? ONE_Q30 : v;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[cnt_r[ADDR_W-1:0]] <= ra_r;
      mem_b[cnt_r[ADDR_W-1:0]] <= rb_new;
    end
    rd_a_r <= mem_a[idx_r[ADDR_W-1:0]];
    rd_b_r <= mem_b[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      flags_r  <= '0;
      cnt_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      div_go_r <= 1'b0;
      ph_r     <= '0;
    end else begin
      div_go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            ent_r <= pop_data;
            if (pop_data.kind == KIND_RET) begin
              state_r <= S_LOAD;
            end else begin
              if (pop_data.kind == KIND_ZERO) begin
                flags_r[0] <= 1'b1;
              end
              if (pop_data.kind == KIND_OVF) begin
                flags_r[1] <= 1'b1;
              end
              state_r <= pop_data.last ? S_FINAL : S_IDLE;
            end
          end
        end
        S_LOAD: begin
          div_go_r  <= 1'b1;
          div_num_r <= {4'b0, dif_a, 28'b0};
          div_den_r <= ent_r.prev_a;
          state_r   <= S_DIVA;
        end
        S_DIVA: begin
          if (div_done) begin
            ra_r      <= sat_ret(div_quo, ent_r.price_a < ent_r.prev_a);
            div_go_r  <= 1'b1;
            div_num_r <= {4'b0, dif_b, 28'b0};
            div_den_r <= ent_r.prev_b;
            state_r   <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            sum_a_r <= sum_a_r + SUM_W'($signed(ra_r));
            sum_b_r <= sum_b_r + SUM_W'($signed(rb_new));
            cnt_r   <= cnt_r + 1'b1;
            state_r <= ent_r.last ? S_FINAL : S_IDLE;
          end
        end
        S_FINAL: begin
          corr_r <= '0;
          if (flags_r[0]) begin
            status_r <= ST_ZERO_PRICE;
            state_r  <= S_OUT;
          end else if (flags_r[1]) begin
            status_r <= ST_OVERFLOW;
            state_r  <= S_OUT;
          end else if (cnt_r < CNT_W'(2)) begin
            status_r <= ST_FEW;
            state_r  <= S_OUT;
          end else begin
            div_go_r  <= 1'b1;
            div_num_r <= 64'(sum_a_mag);
            div_den_r <= 32'(cnt_r);
            state_r   <= S_MEANA;
          end
        end
        S_MEANA: begin
          if (div_done) begin
            ma_r      <= sum_a_r[SUM_W-1] ? RET_W'(-div_quo[RET_W-1:0])
                                          : div_quo[RET_W-1:0];
            div_go_r  <= 1'b1;
            div_num_r <= 64'(sum_b_mag);
            div_den_r <= 32'(cnt_r);
            state_r   <= S_MEANB;
          end
        end
        S_MEANB: begin
          if (div_done) begin
            mb_r    <= sum_b_r[SUM_W-1] ? RET_W'(-div_quo[RET_W-1:0])
                                        : div_quo[RET_W-1:0];
            idx_r   <= '0;
            ph_r    <= '0;
            c1_r    <= '0;
            c2_r    <= '0;
            c_r     <= '0;
            state_r <= S_PASS;
          end
        end
        S_PASS: begin
          case (ph_r)
            3'd0: begin
              ph_r <= 3'd1;
            end
            3'd1: begin
              ua_r     <= da_mag[31:0];
              ub_r     <= db_mag[31:0];
              na_neg_r <= da[33];
              nb_neg_r <= db[33];
              ph_r     <= 3'd2;
            end
            3'd2: begin
              prod_r <= mul_res;
              ph_r   <= 3'd3;
            end
            3'd3: begin
              c1_r   <= c1_r + (prod_r >> 17);
              prod_r <= mul_res;
              ph_r   <= 3'd4;
            end
            3'd4: begin
              c2_r   <= c2_r + (prod_r >> 17);
              prod_r <= mul_res;
              ph_r   <= 3'd5;
            end
            default: begin
              if (na_neg_r != nb_neg_r) begin
                c_r <= c_r - $signed(prod_r >> 17);
              end else begin
                c_r <= c_r + $signed(prod_r >> 17);
              end
              idx_r <= idx_r + 1'b1;
              ph_r  <= 3'd0;
              if (CNT_W'(idx_r + 1'b1) == cnt_r) begin
                state_r <= S_CHECK;
              end
            end
          endcase
        end
        S_CHECK: begin
          corr_r   <= '0;
          status_r <= ST_OK;
          na_r     <= c1_r;
          nb_r     <= c2_r;
          nc_r     <= c_r[63] ? 64'(-c_r) : 64'(c_r);
          ka_r     <= '0;
          kb_r     <= '0;
          kc_r     <= '0;
          if (c1_r == '0 || c2_r == '0) begin
            status_r <= ST_ZERO_VAR;
            state_r  <= S_OUT;
          end else if (c_r == '0) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (na_r < NORM4_MIN) begin
            na_r <= na_r << 2;
            ka_r <= ka_r + 6'd1;
          end
          if (nb_r < NORM4_MIN) begin
            nb_r <= nb_r << 2;
            kb_r <= kb_r + 6'd1;
          end
          if (nc_r < NORM2_MIN) begin
            nc_r <= nc_r << 1;
            kc_r <= kc_r + 6'd1;
          end
          if (na_r >= NORM4_MIN && nb_r >= NORM4_MIN && nc_r >= NORM2_MIN) begin
            ya_r    <= na_r;
            yb_r    <= nb_r;
            qa_r    <= '0;
            qb_r    <= '0;
            bit_r   <= NORM4_MIN;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ya_r >= ta) begin
            ya_r <= ya_r - ta;
            qa_r <= (qa_r >> 1) + bit_r;
          end else begin
            qa_r <= qa_r >> 1;
          end
          if (yb_r >= tb) begin
            yb_r <= yb_r - tb;
            qb_r <= (qb_r >> 1) + bit_r;
          end else begin
            qb_r <= qb_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= S_PROD;
          end
        end
        S_PROD: begin
          p_r     <= mul_res;
          state_r <= S_RSTART;
        end
        S_RSTART: begin
          div_go_r  <= 1'b1;
          div_num_r <= nc_r;
          div_den_r <= p_r[61:30];
          state_r   <= S_RATIO;
        end
        S_RATIO: begin
          if (div_done) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          corr_r  <= c_r[63] ? CORR_W'(-v_cl[CORR_W-1:0]) : v_cl[CORR_W-1:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_chan.ready) begin
            flags_r <= '0;
            cnt_r   <= '0;
            sum_a_r <= '0;
            sum_b_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/pearson_correlation_of_returns.sv =====
// Pearson correlation of the relative returns of two price series.
// in_chan carries one pair of closing prices per item, with last on the
// final pair of a run; out_chan carries one result item (correlation in
// signed Q2.30 and a status code) for each item marked last, none else.
// Both channels transfer an item when valid and ready are high at a clock edge.
// Items pass through a two-entry queue to the back end, which works on one
// item at a time. A pair that yields returns runs the bit-serial divider
// twice; other pairs need no division. After the last pair the result
// for n returns takes two mean divisions, a second pass per stored return
// through one multiplier, a normalization, a 31-step square root and a
// final division. Errors found early are reported without the divisions.
// While out_chan is stalled the result is held and the queue still takes
// up to two further items. Synchronous reset clears the run state; the
// return memories need no clearing.
module pearson_correlation_of_returns (
  input  logic      clk,
  input  logic      rst_n,
  pcr_in_if.sink    in_chan,
  pcr_out_if.source out_chan
);
  import pcr_pkg::*;

  logic        push_valid;
  logic        push_ready;
  pcr_ent_t    push_data;
  logic        pop_valid;
  logic        pop;
  pcr_ent_t    pop_data;
  logic        div_start;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;

  pcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  pcr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  pcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  pcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo),
    .out_chan  (out_chan)
  );
endmodule

// ===== rtl/pcr_checker.sv =====
module pcr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pcr_pkg::CORR_W-1:0] out_correlation,
  input logic [pcr_pkg::STATUS_W-1:0]      out_status
);
  import pcr_pkg::*;
  `include "pearson_correlation_of_returns_macros.svh"

  `PCR_ASSERT_IMP(a_err_zero, out_valid && out_status != ST_OK, out_correlation == '0)
  `PCR_ASSERT_IMP(a_corr_range, out_valid, out_correlation <= 32'sd1073741824 && out_correlation >= -32'sd1073741824)
  `PCR_ASSERT_IMP(a_status_code, out_valid, out_status <= ST_OVERFLOW)
  `PCR_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_correlation) && $stable(out_status))
  `PCR_ASSERT_RST(a_reset_idle, !out_valid)
endmodule

bind pearson_correlation_of_returns pcr_checker u_pcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_correlation (out_chan.correlation),
  .out_status      (out_chan.status)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pcr_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic signed [CORR_W-1:0] corr;
    logic [STATUS_W-1:0]      status;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pcr_in_if  in_if ();
  pcr_out_if out_if ();

  pearson_correlation_of_returns u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #5 clk = ~clk;

  corr_result_t pending_results[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           quiet = 1'b0;

  // Model of the block's run state.
  logic [RET_W-1:0]   store_a[MAX_RETURNS];
  logic [RET_W-1:0]   store_b[MAX_RETURNS];
  logic [PRICE_W-1:0] prev_a, prev_b;
  int unsigned        pairs_seen;
  longint             total_a, total_b;
  logic [1:0]         fault_bits;

  function automatic longint price_return(input logic [31:0] p, input logic [31:0] prev);
    logic [63:0] q;
    if (p >= prev) begin
      q = ({32'd0, p - prev} << 28) / {32'd0, prev};
      return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    end
    q = ({32'd0, prev - p} << 28) / {32'd0, prev};
    return -longint'(q);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] y);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > y) b = b >> 2;
    while (b != 0) begin
      if (y >= r + b) begin
        y = y - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] coefficient(input longint c, input logic [63:0] v1,
                                                     input logic [63:0] v2);
    int          ka, kb, kc, e;
    logic [63:0] sa, sb, p, mc, r, v;
    ka = 0;
    kb = 0;
    kc = 0;
    if (c == 0) return 0;
    while (v1 < (64'd1 << 60)) begin v1 = v1 << 2; ka++; end
    while (v1 >= (64'd1 << 62)) begin v1 = v1 >> 2; ka--; end
    while (v2 < (64'd1 << 60)) begin v2 = v2 << 2; kb++; end
    while (v2 >= (64'd1 << 62)) begin v2 = v2 >> 2; kb--; end
    sa = int_sqrt(v1);
    sb = int_sqrt(v2);
    p = sa * sb;
    mc = magnitude(c);
    while (mc < (64'd1 << 61)) begin mc = mc << 1; kc++; end
    while (mc >= (64'd1 << 62)) begin mc = mc >> 1; kc--; end
    r = mc / (p >> 30);
    e = ka + kb - kc;
    if (e >= 0) v = (e >= 32) ? 64'd1 << 30 : r << e;
    else v = (-e >= 64) ? 64'd0 : r >> (-e);
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    return (c < 0) ? -32'(v) : 32'(v);
  endfunction

  task automatic clear_run();
    prev_a = 0;
    prev_b = 0;
    pairs_seen = 0;
    total_a = 0;
    total_b = 0;
    fault_bits = 0;
  endtask

  task automatic predict_pair(input logic [31:0] pa, input logic [31:0] pb, input logic lst);
    longint       ra, rb, ma, mb, da, db, cov;
    logic [63:0]  ua, ub, c1, c2;
    int unsigned  n;
    corr_result_t res;
    if (pairs_seen > 0) begin
      if (prev_a == 0 || prev_b == 0) begin
        fault_bits[0] = 1'b1;
      end else if (pairs_seen - 1 >= MAX_RETURNS) begin
        fault_bits[1] = 1'b1;
      end else begin
        ra = price_return(pa, prev_a);
        rb = price_return(pb, prev_b);
        store_a[pairs_seen - 1] = ra[31:0];
        store_b[pairs_seen - 1] = rb[31:0];
        total_a += ra;
        total_b += rb;
      end
    end
    if (pairs_seen <= MAX_RETURNS) pairs_seen++;
    prev_a = pa;
    prev_b = pb;
    if (!lst) return;
    n = pairs_seen - 1;
    res.corr = 0;
    if (fault_bits[0]) begin
      res.status = ST_ZERO_PRICE;
    end else if (fault_bits[1]) begin
      res.status = ST_OVERFLOW;
    end else if (n < 2) begin
      res.status = ST_FEW;
    end else begin
      ma = total_a / longint'(n);
      mb = total_b / longint'(n);
      c1 = 0;
      c2 = 0;
      cov = 0;
      for (int unsigned i = 0; i < n && i < MAX_RETURNS; i++) begin
        da = longint'(signed'(store_a[i])) - ma;
        db = longint'(signed'(store_b[i])) - mb;
        ua = magnitude(da);
        ub = magnitude(db);
        c1 += (ua * ua) >> 17;
        c2 += (ub * ub) >> 17;
        if ((da < 0) != (db < 0)) cov -= longint'((ua * ub) >> 17);
        else cov += longint'((ua * ub) >> 17);
      end
      if (c1 == 0 || c2 == 0) begin
        res.status = ST_ZERO_VAR;
      end else begin
        res.status = ST_OK;
        res.corr = coefficient(cov, c1, c2);
      end
    end
    pending_results.push_back(res);
    clear_run();
  endtask

  // Called at a rising edge; returns at the edge where the pair is taken.
  task automatic send_pair(input logic [31:0] pa, input logic [31:0] pb, input logic lst);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.price_a <= pa;
    in_if.price_b <= pb;
    in_if.last <= lst;
    do @(posedge clk); while (!in_if.ready);
    predict_pair(pa, pb, lst);
  endtask

  function automatic logic [31:0] next_price(input logic [31:0] prev);
    logic [31:0] step;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(1, 1000);
      default: begin
        step = prev >> $urandom_range(2, 12);
        step = step == 0 ? 1 : $urandom_range(0, step);
        if ($urandom_range(0, 1)) return (prev > step) ? prev - step : prev + step;
        return (prev + step < prev) ? prev - step : prev + step;
      end
    endcase
  endfunction

  task automatic send_run(input int len, input bit allow_zero);
    logic [31:0] a, b;
    int          mode;
    a = $urandom | 1;
    b = $urandom_range(0, 1) ? a : ($urandom | 1);
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      send_pair(a, b, i == len - 1);
      a = next_price(a);
      case (mode)
        0: b = a;
        1: b = ~a | 1;
        default: b = next_price(b);
      endcase
      if (a == 0) a = 1;
      if (b == 0) b = 1;
      if (allow_zero && $urandom_range(0, 40) == 0) begin
        if ($urandom_range(0, 1)) a = 0;
        else b = 0;
      end
    end
  endtask

  task automatic test_short_runs();
    send_pair(32'd100, 32'd200, 1'b1);
    send_pair(32'd100, 32'd200, 1'b0);
    send_pair(32'd110, 32'd190, 1'b1);
    send_pair(32'd50, 32'd50, 1'b0);
    send_pair(32'd50, 32'd50, 1'b0);
    send_pair(32'd50, 32'd50, 1'b1);
    send_pair(32'd100, 32'd100, 1'b0);
    send_pair(32'd120, 32'd80, 1'b0);
    send_pair(32'd90, 32'd110, 1'b0);
    send_pair(32'd130, 32'd70, 1'b1);
  endtask

  task automatic test_extremes();
    send_pair(32'd1, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'hFFFF_FFFF, 32'd1, 1'b0);
    send_pair(32'd1, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
  endtask

  task automatic test_zero_price();
    send_pair(32'd0, 32'd10, 1'b0);
    send_pair(32'd5, 32'd11, 1'b0);
    send_pair(32'd6, 32'd12, 1'b1);
    send_pair(32'd10, 32'd10, 1'b0);
    send_pair(32'd11, 32'd9, 1'b0);
    send_pair(32'd12, 32'd8, 1'b0);
    send_pair(32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_store_overflow();
    send_run(MAX_RETURNS + 3, 1'b0);
  endtask

  task automatic test_random_runs();
    int sent;
    sent = 0;
    while (sent < 200) begin
      int len;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 20);
      if (sent > 150) quiet = 1'b1;
      send_run(len, $urandom_range(0, 3) == 0);
      sent += len;
    end
  endtask

  // Result side stalls in short random bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    corr_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: correlation %0d status %0d",
                   out_if.correlation, out_if.status);
      end else begin
        want = pending_results.pop_front();
        if (want.corr !== out_if.correlation || want.status !== out_if.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected correlation %0d status %0d, got %0d status %0d",
                     want.corr, want.status, out_if.correlation, out_if.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.price_a = '0;
    in_if.price_b = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b1;
    clear_run();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_runs();
    test_extremes();
    test_zero_price();
    test_store_overflow();
    test_random_runs();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (pending_results.size() == 0 && mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== pearson_correlation_of_returns.f =====
+incdir+rtl
rtl/pcr_pkg.sv
rtl/pcr_in_if.sv
rtl/pcr_out_if.sv
rtl/pcr_front.sv
rtl/pcr_fifo.sv
rtl/pcr_div.sv
rtl/pcr_back.sv
rtl/pearson_correlation_of_returns.sv
rtl/pcr_checker.sv
sim/tb_top.sv
